>>> sv/rrpp_pkg.sv
package rrpp_pkg;

   localparam int MAX_DIM_DEF       = 4096;
   localparam int SUBPIXEL_BITS_DEF = 4;

   localparam int PIXEL_W = 12;
   localparam int CHAN_W  = 8;
   localparam int CSR_W   = 24;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] REG_PILL_WIDTH    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PILL_HEIGHT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CORNER_RADIUS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BORDER_WIDTH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FILL_RGB      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_FILL_ALPHA    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_BORDER_ALPHA  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_ACCENT_RGB    = 3'd7;

   typedef struct packed {
      logic [12:0] pill_width;
      logic [12:0] pill_height;
      logic [14:0] corner_radius;
      logic [9:0]  border_width;
      logic [23:0] fill_rgb;
      logic [7:0]  fill_alpha;
      logic [7:0]  border_alpha;
      logic [23:0] accent_rgb;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      pill_width:    13'd66,
      pill_height:   13'd66,
      corner_radius: 15'd240,
      border_width:  10'd67,
      fill_rgb:      24'h161E23,
      fill_alpha:    8'd217,
      border_alpha:  8'd140,
      accent_rgb:    24'h4AB3E0
   };

   // Signed width of the distance datapath in subpixel units.
   function automatic int coord_width(int md, int sb);
      int lg;
      lg = $clog2(md);
      if (lg < 13) lg = 13;
      return lg + sb + 3;
   endfunction

endpackage

>>> sv/rrpp_req_if.sv
interface rrpp_req_if import rrpp_pkg::*;;
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel_x;
   logic [PIXEL_W-1:0] pixel_y;

   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

>>> sv/rrpp_rsp_if.sv
interface rrpp_rsp_if import rrpp_pkg::*;;
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;
   logic [CHAN_W-1:0] alpha;

   modport source (output valid, output red, output green, output blue, output alpha,
                   input ready);
   modport sink   (input valid, input red, input green, input blue, input alpha,
                   output ready);
endinterface

>>> sv/rrpp_geom.sv
module rrpp_geom import rrpp_pkg::*; #(
   parameter int MAX_DIM       = MAX_DIM_DEF,
   parameter int SUBPIXEL_BITS = SUBPIXEL_BITS_DEF,
   localparam int CW = coord_width(MAX_DIM, SUBPIXEL_BITS),
   localparam int NW = 2 * CW - 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_vld,
   input  logic [PIXEL_W-1:0]   pixel_x,
   input  logic [PIXEL_W-1:0]   pixel_y,
   input  cfg_type              cfg,
   output logic                 out_vld,
   output logic [NW-1:0]        out_n,
   output logic signed [CW-1:0] out_mx
);

   localparam logic signed [CW-1:0] HALF = CW'(1 << (SUBPIXEL_BITS - 1));
   localparam logic signed [CW-1:0] DIM_MAX = CW'(MAX_DIM);

   // Distance past the half size less the radius, along one axis.
   function automatic logic signed [CW-1:0] axis_q(logic [PIXEL_W-1:0] c, logic [12:0] d,
                                                   logic [14:0] rad);
      logic signed [CW-1:0] dim, hw, pc, dc, adc;
      dim = $signed(CW'(d));
      if (dim > DIM_MAX) dim = DIM_MAX;
      hw  = dim <<< (SUBPIXEL_BITS - 1);
      pc  = ($signed(CW'(c)) <<< SUBPIXEL_BITS) + HALF;
      dc  = pc - hw;
      adc = dc[CW-1] ? -dc : dc;
      return adc - (hw - $signed(CW'(rad)));
   endfunction

   logic signed [CW-1:0] qx, qy;
   logic [CW-2:0]        ax_in, ay_in;
   logic signed [CW-1:0] mx_in;

   logic                 vld1_ff, vld2_ff, vld3_ff;
   logic [CW-2:0]        ax_ff, ay_ff;
   logic signed [CW-1:0] mx1_ff, mx2_ff, mx3_ff;
   logic [2*CW-3:0]      sqx_ff, sqy_ff;
   logic [NW-1:0]        n_ff;

   always_comb begin
      qx    = axis_q(pixel_x, cfg.pill_width, cfg.corner_radius);
      qy    = axis_q(pixel_y, cfg.pill_height, cfg.corner_radius);
      ax_in = qx[CW-1] ? '0 : qx[CW-2:0];
      ay_in = qy[CW-1] ? '0 : qy[CW-2:0];
      mx_in = (qx > qy) ? qx : qy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else if (adv) begin
         vld1_ff <= in_vld;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ax_ff  <= ax_in;
         ay_ff  <= ay_in;
         mx1_ff <= mx_in;
         sqx_ff <= ax_ff * ax_ff;
         sqy_ff <= ay_ff * ay_ff;
         mx2_ff <= mx1_ff;
         n_ff   <= NW'(sqx_ff) + NW'(sqy_ff);
         mx3_ff <= mx2_ff;
      end
   end

   assign out_vld = vld3_ff;
   assign out_n   = n_ff;
   assign out_mx  = mx3_ff;

endmodule

>>> sv/rrpp_sqrt.sv
module rrpp_sqrt import rrpp_pkg::*; #(
   parameter int MAX_DIM       = MAX_DIM_DEF,
   parameter int SUBPIXEL_BITS = SUBPIXEL_BITS_DEF,
   localparam int CW = coord_width(MAX_DIM, SUBPIXEL_BITS),
   localparam int NW = 2 * CW - 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_vld,
   input  logic [NW-1:0]        in_n,
   input  logic signed [CW-1:0] in_mx,
   output logic                 out_vld,
   output logic [CW-1:0]        out_root,
   output logic                 out_inc,
   output logic signed [CW-1:0] out_mx
);

   localparam int RW = NW + 1;

   logic [RW-1:0]        rem_ff  [CW];
   logic [RW-1:0]        root_ff [CW];
   logic signed [CW-1:0] mx_ff   [CW];
   logic                 vld_ff  [CW];
   logic [RW-1:0]        rem_in  [CW];
   logic [RW-1:0]        root_in [CW];

   // One result bit per stage, from the top bit pair down.
   for (genvar i = 0; i < CW; i++) begin : g_stage
      localparam logic [RW-1:0] BIT = RW'(1) << (2 * (CW - 1 - i));
      logic [RW-1:0]        rem_src, root_src, trial;
      logic signed [CW-1:0] mx_src;
      logic                 vld_src;

      if (i == 0) begin : g_first
         assign rem_src  = RW'(in_n);
         assign root_src = '0;
         assign mx_src   = in_mx;
         assign vld_src  = in_vld;
      end else begin : g_next
         assign rem_src  = rem_ff[i-1];
         assign root_src = root_ff[i-1];
         assign mx_src   = mx_ff[i-1];
         assign vld_src  = vld_ff[i-1];
      end

      assign trial = root_src + BIT;

      always_comb begin
         if (rem_src >= trial) begin
            rem_in[i]  = rem_src - trial;
            root_in[i] = (root_src >> 1) + BIT;
         end else begin
            rem_in[i]  = rem_src;
            root_in[i] = root_src >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (adv) begin
            vld_ff[i] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[i]  <= rem_in[i];
            root_ff[i] <= root_in[i];
            mx_ff[i]   <= mx_src;
         end
      end
   end

   assign out_vld  = vld_ff[CW-1];
   assign out_root = root_ff[CW-1][CW-1:0];
   // Round to nearest: the remainder exceeds the root past the halfway point.
   assign out_inc  = rem_ff[CW-1] > root_ff[CW-1];
   assign out_mx   = mx_ff[CW-1];

endmodule

>>> sv/rrpp_shade.sv
module rrpp_shade import rrpp_pkg::*; #(
   parameter int MAX_DIM       = MAX_DIM_DEF,
   parameter int SUBPIXEL_BITS = SUBPIXEL_BITS_DEF,
   localparam int CW = coord_width(MAX_DIM, SUBPIXEL_BITS)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_vld,
   input  logic [CW-1:0]        in_root,
   input  logic                 in_inc,
   input  logic signed [CW-1:0] in_mx,
   input  cfg_type              cfg,
   output logic                 out_vld,
   output logic [CHAN_W-1:0]    red,
   output logic [CHAN_W-1:0]    green,
   output logic [CHAN_W-1:0]    blue,
   output logic [CHAN_W-1:0]    alpha
);

   localparam int S   = SUBPIXEL_BITS;
   localparam int DW  = CW + 2;
   localparam int VW  = S + 1;
   localparam int TW  = S + 9;
   localparam int AW  = TW + VW;
   localparam int PW  = 9 + TW + 1;
   localparam int ONE = 1 << S;
   localparam int DEN = 255 * ONE;
   localparam logic signed [DW-1:0] HALF_S = DW'(ONE / 2);
   localparam logic signed [DW-1:0] ONE_S  = DW'(ONE);

   function automatic logic [VW-1:0] clamp_cov(logic signed [DW-1:0] v);
      logic [VW-1:0] r;
      if (v < 0) r = '0;
      else if (v > ONE_S) r = VW'(ONE);
      else r = v[VW-1:0];
      return r;
   endfunction

   // Stage 1: signed distance.
   logic signed [DW-1:0] dist_in, dist_ff;
   logic                 vld1_ff;
   // Stage 2: coverage and border fraction.
   logic signed [DW-1:0] t_cov, t_inner;
   logic [VW-1:0]        cov_in, inner, bf_in;
   logic [VW-1:0]        cov2_ff, bf2_ff;
   logic                 vld2_ff;
   // Stage 3: border weight.
   logic [TW-1:0]        tnum_ff;
   logic [VW-1:0]        cov3_ff;
   logic                 vld3_ff;
   // Stage 4: products.
   logic [TW-1:0]        m_in;
   logic signed [PW-1:0] prod_in  [3];
   logic signed [PW-1:0] prod_ff  [3];
   logic [AW-1:0]        anum_ff;
   logic                 zero4_ff, vld4_ff;
   // Stage 5: rounded numerators scaled down to a quotient by 255.
   logic signed [PW-1:0] num_in   [3];
   logic [15:0]          u_ff     [3];
   logic [AW-1:0]        asum;
   logic [CHAN_W-1:0]    alpha5_ff;
   logic                 zero5_ff, vld5_ff;
   // Stage 6: divide by 255 and output.
   logic [23:0]          recip    [3];
   logic [7:0]           q0       [3];
   logic [16:0]          rm       [3];
   logic [8:0]           q        [3];
   logic [CHAN_W-1:0]    chan_in  [3];
   logic [CHAN_W-1:0]    chan_ff  [3];
   logic [CHAN_W-1:0]    alpha_ff;
   logic                 vld6_ff;

   always_comb begin
      dist_in = $signed(DW'(in_root)) + $signed(DW'(in_inc))
              + (in_mx[CW-1] ? DW'(in_mx) : DW'(0))
              - $signed(DW'(cfg.corner_radius));
   end

   always_comb begin
      t_cov   = HALF_S - dist_ff;
      t_inner = t_cov - $signed(DW'(cfg.border_width));
      cov_in  = clamp_cov(t_cov);
      inner   = clamp_cov(t_inner);
      bf_in   = (cov_in > inner) ? cov_in - inner : '0;
   end

   always_comb begin
      m_in = TW'(cfg.fill_alpha) << S;
      if (tnum_ff > m_in) m_in = tnum_ff;
      for (int j = 0; j < 3; j++) begin
         prod_in[j] = PW'($signed({1'b0, cfg.accent_rgb[8*j +: 8]})
                         - $signed({1'b0, cfg.fill_rgb[8*j +: 8]}))
                    * $signed({1'b0, tnum_ff});
      end
   end

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         num_in[j] = $signed(PW'(cfg.fill_rgb[8*j +: 8]) * PW'(DEN)) + prod_ff[j]
                   + $signed(PW'(DEN / 2));
      end
      asum = anum_ff + AW'(ONE * ONE / 2);
   end

   // Quotient by 255 through a reciprocal estimate that is low by at most one.
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         recip[j] = {u_ff[j], 8'd0} + 24'(u_ff[j]);
         q0[j]    = recip[j][23:16];
         rm[j]    = 17'(u_ff[j]) - 17'(q0[j]) * 17'd255;
         q[j]     = (rm[j] >= 17'd255) ? 9'(q0[j]) + 9'd1 : 9'(q0[j]);
         if (zero5_ff) chan_in[j] = '0;
         else if (q[j][8]) chan_in[j] = 8'hFF;
         else chan_in[j] = q[j][7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
         vld5_ff <= 1'b0;
         vld6_ff <= 1'b0;
      end else if (adv) begin
         vld1_ff <= in_vld;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         vld4_ff <= vld3_ff;
         vld5_ff <= vld4_ff;
         vld6_ff <= vld5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dist_ff   <= dist_in;
         cov2_ff   <= cov_in;
         bf2_ff    <= bf_in;
         tnum_ff   <= TW'(bf2_ff) * TW'(cfg.border_alpha);
         cov3_ff   <= cov2_ff;
         anum_ff   <= AW'(m_in) * AW'(cov3_ff);
         zero4_ff  <= (cov3_ff == '0);
         zero5_ff  <= zero4_ff;
         alpha5_ff <= asum[2*S+7:2*S];
         alpha_ff  <= zero5_ff ? '0 : alpha5_ff;
         for (int j = 0; j < 3; j++) begin
            prod_ff[j] <= prod_in[j];
            u_ff[j]    <= num_in[j][S+15:S];
            chan_ff[j] <= chan_in[j];
         end
      end
   end

   assign out_vld = vld6_ff;
   assign red     = chan_ff[0];
   assign green   = chan_ff[1];
   assign blue    = chan_ff[2];
   assign alpha   = alpha_ff;

endmodule

>>> sv/rounded_rect_pill_pixel.sv
// Channel   Direction  Word
// req_ch    in         pixel_x[11:0], pixel_y[11:0]
// rsp_ch    out        red, green, blue, alpha, 8 bits each
// csr_*     in         csr_we, csr_index[2:0], csr_wdata[23:0]
//
// One pixel word is accepted every cycle unless a finished word waits untaken;
// most of the pipeline is the square root, which resolves one
// result bit per stage. The whole pipeline holds when the output word is not taken.
// Reset clears the valid bits and loads the register defaults.
module rounded_rect_pill_pixel import rrpp_pkg::*; #(
   parameter int MAX_DIM       = MAX_DIM_DEF,
   parameter int SUBPIXEL_BITS = SUBPIXEL_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   rrpp_req_if.sink             req_ch,
   rrpp_rsp_if.source           rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam int CW = coord_width(MAX_DIM, SUBPIXEL_BITS);
   localparam int NW = 2 * CW - 1;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_PILL_WIDTH:    cfg_ff.pill_width    <= csr_wdata[12:0];
            REG_PILL_HEIGHT:   cfg_ff.pill_height   <= csr_wdata[12:0];
            REG_CORNER_RADIUS: cfg_ff.corner_radius <= csr_wdata[14:0];
            REG_BORDER_WIDTH:  cfg_ff.border_width  <= csr_wdata[9:0];
            REG_FILL_RGB:      cfg_ff.fill_rgb      <= csr_wdata;
            REG_FILL_ALPHA:    cfg_ff.fill_alpha    <= csr_wdata[7:0];
            REG_BORDER_ALPHA:  cfg_ff.border_alpha  <= csr_wdata[7:0];
            REG_ACCENT_RGB:    cfg_ff.accent_rgb    <= csr_wdata;
         endcase
      end
   end

   logic                 adv;
   logic                 g_vld, s_vld, o_vld;
   logic [NW-1:0]        g_n;
   logic signed [CW-1:0] g_mx, s_mx;
   logic [CW-1:0]        s_root;
   logic                 s_inc;

   // Every stage moves together unless a finished word is waiting and not taken.
   assign adv          = !o_vld || rsp_ch.ready;
   assign req_ch.ready = adv;
   assign rsp_ch.valid = o_vld;

   rrpp_geom #(.MAX_DIM(MAX_DIM), .SUBPIXEL_BITS(SUBPIXEL_BITS)) u_geom (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_vld  (req_ch.valid),
      .pixel_x (req_ch.pixel_x),
      .pixel_y (req_ch.pixel_y),
      .cfg     (cfg_ff),
      .out_vld (g_vld),
      .out_n   (g_n),
      .out_mx  (g_mx)
   );

   rrpp_sqrt #(.MAX_DIM(MAX_DIM), .SUBPIXEL_BITS(SUBPIXEL_BITS)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (g_vld),
      .in_n     (g_n),
      .in_mx    (g_mx),
      .out_vld  (s_vld),
      .out_root (s_root),
      .out_inc  (s_inc),
      .out_mx   (s_mx)
   );

   rrpp_shade #(.MAX_DIM(MAX_DIM), .SUBPIXEL_BITS(SUBPIXEL_BITS)) u_shade (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_vld  (s_vld),
      .in_root (s_root),
      .in_inc  (s_inc),
      .in_mx   (s_mx),
      .cfg     (cfg_ff),
      .out_vld (o_vld),
      .red     (rsp_ch.red),
      .green   (rsp_ch.green),
      .blue    (rsp_ch.blue),
      .alpha   (rsp_ch.alpha)
   );

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb import rrpp_pkg::*;;

   localparam int ONE = 1 << SUBPIXEL_BITS_DEF;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT = 2000000;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } rgba_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0] csr_wdata;

   rrpp_req_if req_ch();
   rrpp_rsp_if rsp_ch();

   rounded_rect_pill_pixel DUT (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   cfg_type shade_cfg;
   rgba_type expected_pixels[$];
   int send_idle_pct;
   int recv_idle_pct;
   int mismatches;
   int cycles;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic longint sqrt_nearest(longint unsigned n);
      longint unsigned r, bits, rem;
      r = 0;
      bits = 64'd1 << 62;
      rem = n;
      while (bits > rem) bits = bits >> 2;
      while (bits != 0) begin
         if (rem >= r + bits) begin
            rem = rem - (r + bits);
            r = (r >> 1) + bits;
         end else begin
            r = r >> 1;
         end
         bits = bits >> 2;
      end
      if (rem > r) r = r + 1;
      return longint'(r);
   endfunction

   function automatic longint clampl(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic logic [7:0] mix_channel(longint f8, longint a8, longint tnum);
      longint den, num;
      den = ONE * 255;
      num = f8 * den + (a8 - f8) * tnum;
      if (num < 0) num = 0;
      return 8'(clampl((num + den / 2) / den, 0, 255));
   endfunction

   function automatic rgba_type shade_pixel(logic [11:0] px, logic [11:0] py);
      longint wpx, hpx, rad, bw, hw, hh, qx, qy, ax, ay, t;
      longint outside, mx, sdist, cov, inner, bf, tnum, m;
      rgba_type res;
      wpx = shade_cfg.pill_width > MAX_DIM_DEF ? MAX_DIM_DEF : shade_cfg.pill_width;
      hpx = shade_cfg.pill_height > MAX_DIM_DEF ? MAX_DIM_DEF : shade_cfg.pill_height;
      rad = shade_cfg.corner_radius;
      bw = shade_cfg.border_width;
      hw = wpx * ONE / 2;
      hh = hpx * ONE / 2;
      t = longint'(px) * ONE + ONE / 2 - hw;
      if (t < 0) t = -t;
      qx = t - (hw - rad);
      t = longint'(py) * ONE + ONE / 2 - hh;
      if (t < 0) t = -t;
      qy = t - (hh - rad);
      ax = qx > 0 ? qx : 0;
      ay = qy > 0 ? qy : 0;
      outside = sqrt_nearest(ax * ax + ay * ay);
      mx = qx > qy ? qx : qy;
      sdist = outside + (mx < 0 ? mx : 0) - rad;
      cov = clampl(ONE / 2 - sdist, 0, ONE);
      res = '0;
      if (cov > 0) begin
         inner = clampl(ONE / 2 - (sdist + bw), 0, ONE);
         bf = clampl(cov - inner, 0, ONE);
         tnum = bf * shade_cfg.border_alpha;
         res.red = mix_channel(shade_cfg.fill_rgb[7:0], shade_cfg.accent_rgb[7:0], tnum);
         res.green = mix_channel(shade_cfg.fill_rgb[15:8], shade_cfg.accent_rgb[15:8], tnum);
         res.blue = mix_channel(shade_cfg.fill_rgb[23:16], shade_cfg.accent_rgb[23:16], tnum);
         m = longint'(shade_cfg.fill_alpha) * ONE;
         if (tnum > m) m = tnum;
         res.alpha = 8'(clampl((m * cov + ONE * ONE / 2) / (ONE * ONE), 0, 255));
      end
      return res;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("** rounded_rect_pill_pixel: FAILED **");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Each word taken from the block is matched against the oldest prediction.
   always @(posedge clock) begin
      rgba_type got, want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{rsp_ch.red, rsp_ch.green, rsp_ch.blue, rsp_ch.alpha};
         if (expected_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %h", got);
         end else begin
            want = expected_pixels.pop_front();
            if (got.red !== want.red || got.green !== want.green ||
                got.blue !== want.blue || got.alpha !== want.alpha) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch rgba expected %h actual %h", want, got);
            end
         end
      end
   end

   task automatic send_pixel(input logic [11:0] px, input logic [11:0] py);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.pixel_x <= px;
      req_ch.pixel_y <= py;
      do @(posedge clock); while (!req_ch.ready);
      expected_pixels = {expected_pixels, shade_pixel(px, py)};
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (expected_pixels.size() != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_PILL_WIDTH:    shade_cfg.pill_width = val[12:0];
         REG_PILL_HEIGHT:   shade_cfg.pill_height = val[12:0];
         REG_CORNER_RADIUS: shade_cfg.corner_radius = val[14:0];
         REG_BORDER_WIDTH:  shade_cfg.border_width = val[9:0];
         REG_FILL_RGB:      shade_cfg.fill_rgb = val;
         REG_FILL_ALPHA:    shade_cfg.fill_alpha = val[7:0];
         REG_BORDER_ALPHA:  shade_cfg.border_alpha = val[7:0];
         REG_ACCENT_RGB:    shade_cfg.accent_rgb = val;
         default: ;
      endcase
   endtask

   task automatic set_shape(input int w, input int h, input int rad, input int bw);
      write_reg(REG_PILL_WIDTH, CSR_W'(w));
      write_reg(REG_PILL_HEIGHT, CSR_W'(h));
      write_reg(REG_CORNER_RADIUS, CSR_W'(rad));
      write_reg(REG_BORDER_WIDTH, CSR_W'(bw));
   endtask

   task automatic set_colors(input int frgb, input int fa, input int ba, input int argb);
      write_reg(REG_FILL_RGB, CSR_W'(frgb));
      write_reg(REG_FILL_ALPHA, CSR_W'(fa));
      write_reg(REG_BORDER_ALPHA, CSR_W'(ba));
      write_reg(REG_ACCENT_RGB, CSR_W'(argb));
   endtask

   task automatic test_reset_defaults();
      send_pixel(0, 0);
      send_pixel(33, 33);
      send_pixel(0, 33);
      send_pixel(2, 2);
      send_pixel(65, 65);
      send_pixel(4095, 4095);
   endtask

   task automatic test_extreme_shapes();
      // A width above the maximum saturates, a zero height is degenerate.
      set_shape(8191, 0, 0, 0);
      send_pixel(0, 0);
      send_pixel(4095, 0);
      set_shape(4096, 4096, 32767, 1023);
      set_colors(24'hFFFFFF, 255, 255, 24'h000000);
      send_pixel(2048, 2048);
      send_pixel(0, 0);
      send_pixel(4095, 2048);
      // Radius far above half the box.
      set_shape(1, 1, 200, 1023);
      send_pixel(0, 0);
      send_pixel(1, 0);
      set_shape(20, 10, 0, 16);
      set_colors(24'h000000, 0, 0, 24'hFFFFFF);
      send_pixel(0, 0);
      send_pixel(10, 5);
      send_pixel(19, 9);
      send_pixel(20, 10);
      set_colors(24'h123456, 128, 255, 24'hFEDCBA);
      send_pixel(0, 5);
      send_pixel(10, 0);
      send_pixel(3000, 100);
   endtask

   task automatic random_config();
      int w, h, rad, bw, pick;
      pick = $urandom_range(0, 9);
      w = pick < 7 ? $urandom_range(1, 160) : (pick < 9 ? $urandom_range(1, 4096)
          : $urandom_range(0, 8191));
      pick = $urandom_range(0, 9);
      h = pick < 7 ? $urandom_range(1, 160) : (pick < 9 ? $urandom_range(1, 4096)
          : $urandom_range(0, 8191));
      rad = $urandom_range(0, 3) == 0 ? $urandom_range(0, 32767)
            : $urandom_range(0, (w < h ? w : h) * 8 + 32);
      bw = $urandom_range(0, 3) == 0 ? $urandom_range(0, 1023) : $urandom_range(0, 64);
      set_shape(w, h, rad, bw);
      set_colors($urandom_range(0, 24'hFFFFFF), $urandom_range(0, 255),
                 $urandom_range(0, 255), $urandom_range(0, 24'hFFFFFF));
   endtask

   task automatic test_random_pixels(input int phases, input int per_phase);
      int lim_x, lim_y, px, py;
      for (int p = 0; p < phases; p++) begin
         random_config();
         lim_x = shade_cfg.pill_width > 4095 ? 4095 : shade_cfg.pill_width;
         lim_y = shade_cfg.pill_height > 4095 ? 4095 : shade_cfg.pill_height;
         for (int i = 0; i < per_phase; i++) begin
            // Mostly pixels on or near the shape, the rest anywhere.
            if ($urandom_range(0, 9) < 8) begin
               px = $urandom_range(0, lim_x);
               py = $urandom_range(0, lim_y);
            end else begin
               px = $urandom_range(0, 4095);
               py = $urandom_range(0, 4095);
            end
            send_pixel(12'(px), 12'(py));
            if (p == 1 && i == per_phase / 2) wait_drained();
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.pixel_x = '0;
      req_ch.pixel_y = '0;
      rsp_ch.ready = 1'b0;
      mismatches = 0;
      cycles = 0;
      shade_cfg = CFG_RESET;
      send_idle_pct = 27;
      recv_idle_pct = 54;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_defaults();
      test_extreme_shapes();
      test_random_pixels(7, 50);
      send_idle_pct = 54;
      recv_idle_pct = 27;
      test_random_pixels(7, 50);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_pixels(7, 50);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_pixels.size() == 0) begin
         $display("** rounded_rect_pill_pixel: PASSED **");
      end else begin
         $display("** rounded_rect_pill_pixel: FAILED **");
      end
      $finish;
   end

endmodule
